// ===== hdl/detq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed event timer queue package
// Shared codes, field widths and the control structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package detq_pkg;

   localparam int KIND_W   = 6;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_FIRED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [KIND_W-1:0] KIND_NONE = '0;

   typedef struct packed {
      logic load;
      logic insert;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic walk_done;
   } ctrl_status_type;

endpackage

// ===== hdl/delayed_event_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed event timer queue
// Keeps up to QUEUE_DEPTH pending events in arrival order, each with a signed
// countdown, and reports the events that fire on each tick.
// ----------------------------------------------------------------------------
// An insert word gives exactly one result word. A tick word has the
// controller walk the entry registers one entry per cycle through the head
// of the list, while the result side is not stalled; each fired entry gives
// one result word, and a tick with no fired entry gives none. A stalled
// result holds the walk until it is taken, while the next request word can
// be accepted once the walk has finished.
// ----------------------------------------------------------------------------
module delayed_event_timer_queue
   import detq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [KIND_W-1:0]         req_sound_kind,
   input  logic signed [COUNT_W-1:0] req_delay,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [KIND_W-1:0]         rsp_fired_kind,
   output logic                      rsp_last
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   detq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd)
   );

   detq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sound_kind (req_sound_kind),
      .req_delay      (req_delay),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_fired_kind (rsp_fired_kind),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hdl/detq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed event timer queue controller
// Takes one request word at a time and sequences either an insert or a walk
// over the stored entries, one entry per step.
// ----------------------------------------------------------------------------
module detq_ctrl
   import detq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_cmd,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;

   assign req_stall = req_stall_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = req_valid && !req_stall_ff && (state_ff == ST_IDLE);
      cmd.insert = (state_ff == ST_INSERT) && status.out_free;
      cmd.step   = (state_ff == ST_WALK) && status.out_free && !status.walk_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= (req_cmd == CMD_TICK) ? ST_WALK : ST_INSERT;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_INSERT: begin
               if (status.out_free) begin
                  state_ff     <= ST_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            ST_WALK: begin
               if (status.walk_done) begin
                  state_ff     <= ST_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== hdl/detq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed event timer queue datapath
// Entry registers, occupancy, walk counter and the registered result word.
// A walk step takes the head entry, shifts the list down and either emits
// the head or puts it back, decremented, behind the surviving entries.
// ----------------------------------------------------------------------------
module detq_datapath
   import detq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  logic [KIND_W-1:0]         req_sound_kind,
   input  logic signed [COUNT_W-1:0] req_delay,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [KIND_W-1:0]         rsp_fired_kind,
   output logic                      rsp_last
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [KIND_W-1:0]         slot_kind_ff  [QUEUE_DEPTH];
   logic [KIND_W-1:0]         slot_kind_in  [QUEUE_DEPTH];
   logic signed [COUNT_W-1:0] slot_count_ff [QUEUE_DEPTH];
   logic signed [COUNT_W-1:0] slot_count_in [QUEUE_DEPTH];
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic [OCC_W-1:0]          left_ff, left_in;
   logic [KIND_W-1:0]         kind_ff;
   logic signed [COUNT_W-1:0] delay_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [QUEUE_DEPTH-1:0]    fire;
   logic                      later_fire;
   logic                      full;
   logic [OCC_W-1:0]          tail_idx;
   logic [IDX_W-1:0]          ins_idx;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fired_kind = rsp_kind_ff;
   assign rsp_last       = rsp_last_ff;

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.walk_done = (left_ff == '0);

   assign full     = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign tail_idx = occ_ff - OCC_W'(1);
   assign ins_idx  = occ_ff[IDX_W-1:0];

   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         fire[k] = slot_count_ff[k][COUNT_W-1] || (slot_count_ff[k] == '0);
      end
      later_fire = 1'b0;
      for (int k = 1; k < QUEUE_DEPTH; k++) begin
         if ((OCC_W'(k) < left_ff) && fire[k]) begin
            later_fire = 1'b1;
         end
      end
   end

   always_comb begin
      slot_kind_in  = slot_kind_ff;
      slot_count_in = slot_count_ff;
      occ_in        = occ_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load) begin
         left_in = occ_ff;
      end

      if (cmd.insert) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_NONE;
         rsp_last_in  = 1'b1;
         if (full) begin
            rsp_status_in = STATUS_OVERFLOW;
         end else if (kind_ff == KIND_NONE) begin
            rsp_status_in = STATUS_IGNORED;
         end else begin
            rsp_status_in          = STATUS_ACCEPTED;
            slot_kind_in[ins_idx]  = kind_ff;
            slot_count_in[ins_idx] = delay_ff;
            occ_in                 = occ_ff + OCC_W'(1);
         end
      end

      if (cmd.step) begin
         left_in = left_ff - OCC_W'(1);
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            slot_kind_in[k]  = slot_kind_ff[k + 1];
            slot_count_in[k] = slot_count_ff[k + 1];
         end
         if (fire[0]) begin
            occ_in        = tail_idx;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_FIRED;
            rsp_kind_in   = slot_kind_ff[0];
            rsp_last_in   = !later_fire;
         end else begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
               if (OCC_W'(k) == tail_idx) begin
                  slot_kind_in[k]  = slot_kind_ff[0];
                  slot_count_in[k] = slot_count_ff[0] - COUNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_kind_ff  <= slot_kind_in;
      slot_count_ff <= slot_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.load) begin
         kind_ff  <= req_sound_kind;
         delay_ff <= req_delay;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed event timer queue testbench
// Sends insert and tick words with random bursts and gaps, stalls the result
// side on its own random pattern, predicts the fired events and insert
// outcomes per accepted word, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
   import detq_pkg::*;

   localparam int LIST_DEPTH  = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic                      cmd;
      logic [KIND_W-1:0]         kind;
      logic signed [COUNT_W-1:0] delay;
   } timer_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   kind;
      logic                last;
   } report_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_SOLID
   } stall_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_INSERT;
   logic [KIND_W-1:0]         req_sound_kind = KIND_NONE;
   logic signed [COUNT_W-1:0] req_delay = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [KIND_W-1:0]         rsp_fired_kind;
   logic                      rsp_last;

   timer_word_type timer_words[$];
   report_type     expected_reports[$];

   logic [KIND_W-1:0]         list_kind [LIST_DEPTH];
   logic signed [COUNT_W-1:0] list_count[LIST_DEPTH];
   int                        list_fill = 0;

   int error_count = 0;
   int cycle_count = 0;

   delayed_event_timer_queue #(
      .QUEUE_DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_sound_kind(req_sound_kind),
      .req_delay     (req_delay),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_fired_kind(rsp_fired_kind),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic push_insert(input logic [KIND_W-1:0] kind,
                              input logic signed [COUNT_W-1:0] delay);
      timer_word_type w;
      w.cmd   = CMD_INSERT;
      w.kind  = kind;
      w.delay = delay;
      timer_words.push_back(w);
   endtask

   task automatic push_tick();
      timer_word_type w;
      w.cmd   = CMD_TICK;
      w.kind  = 6'($urandom);
      w.delay = 16'($urandom);
      timer_words.push_back(w);
   endtask

   function automatic void apply_timer_word(input timer_word_type w);
      report_type r;
      report_type held;
      logic       have_held;
      int         i;
      int         j;
      if (w.cmd == CMD_INSERT) begin
         r.kind = KIND_NONE;
         r.last = 1'b1;
         if (list_fill >= LIST_DEPTH) begin
            r.status = STATUS_OVERFLOW;
         end else if (w.kind == KIND_NONE) begin
            r.status = STATUS_IGNORED;
         end else begin
            list_kind[list_fill]  = w.kind;
            list_count[list_fill] = w.delay;
            list_fill++;
            r.status = STATUS_ACCEPTED;
         end
         expected_reports.push_back(r);
      end else begin
         have_held = 1'b0;
         i = 0;
         while (i < list_fill) begin
            if (list_count[i] <= 0) begin
               if (have_held) begin
                  expected_reports.push_back(held);
               end
               held.status = STATUS_FIRED;
               held.kind   = list_kind[i];
               held.last   = 1'b0;
               have_held   = 1'b1;
               for (j = i; j < list_fill - 1; j++) begin
                  list_kind[j]  = list_kind[j + 1];
                  list_count[j] = list_count[j + 1];
               end
               list_fill--;
            end else begin
               list_count[i] = list_count[i] - 16'sd1;
               i++;
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            expected_reports.push_back(held);
         end
      end
   endfunction

   always @(posedge clock) begin : drive_words
      timer_word_type drive_word;
      int             burst_left;
      int             gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_timer_word(drive_word);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (timer_words.size() > 0) begin
               drive_word = timer_words.pop_front();
               req_valid      <= 1'b1;
               req_cmd        <= drive_word.cmd;
               req_sound_kind <= drive_word.kind;
               req_delay      <= drive_word.delay;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_reports
      report_type     want;
      stall_mode_type stall_mode;
      int             stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result word: status %0d kind %0d last %0d",
                      rsp_status, rsp_fired_kind, rsp_last);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_fired_kind !== want.kind) begin
                  $error("fired_kind: expected %0d, actual %0d", want.kind, rsp_fired_kind);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 10)
                                                     : $urandom_range(4, 40);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= 1'b1;
            end
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int                        n;
      int                        sel;
      logic [KIND_W-1:0]         kind;
      logic signed [COUNT_W-1:0] delay;

      // Directed words: empty tick, none kind, extremes, overflow, multiple fires.
      push_tick();
      push_insert(KIND_NONE, 16'sd5);
      push_insert(6'd63, -16'sd32768);
      push_insert(6'd1, 16'sd0);
      push_insert(6'd2, -16'sd1);
      push_insert(6'd3, 16'sd1);
      push_insert(6'd4, 16'sd0);
      push_insert(KIND_NONE, 16'sd0);
      push_tick();
      push_tick();
      push_insert(6'd5, 16'sd0);
      push_insert(6'd6, 16'sd0);
      push_insert(6'd7, 16'sd0);
      push_insert(6'd8, 16'sd0);
      push_tick();
      push_insert(6'd9, 16'sd2);
      push_insert(6'd10, 16'sd0);
      push_insert(6'd11, 16'sd3);
      push_insert(6'd12, -16'sd5);
      push_tick();
      push_tick();
      push_tick();
      push_tick();
      push_tick();

      for (n = 0; n < 145; n++) begin
         if ($urandom_range(0, 99) < 42) begin
            push_tick();
         end else begin
            kind = ($urandom_range(0, 99) < 8) ? KIND_NONE : 6'($urandom_range(1, 63));
            sel  = $urandom_range(0, 99);
            if (sel < 65) begin
               delay = 16'($urandom_range(0, 6));
            end else if (sel < 85) begin
               delay = {1'b1, 15'($urandom)};
            end else if (sel < 95) begin
               delay = 16'($urandom_range(7, 14));
            end else begin
               delay = -16'sd1;
            end
            push_insert(kind, delay);
         end
      end
      push_insert(6'd42, 16'sd32767);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (timer_words.size() != 0 || req_valid || expected_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
